[hdl/line_rectangle_rasterizer_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the line and rectangle rasterizer
// Shared shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef LINE_RECTANGLE_RASTERIZER_UNIT_MACROS_SVH
`define LINE_RECTANGLE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, ignored while reset is held.
`define LRR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, ignored while reset is held.
`define LRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define LRR_ASSERT_NEXT_NORST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lrr_pkg.sv]
// ----------------------------------------------------------------------------
// Rasterizer package
// Widths, stream packing constants and shared types of the rasterizer.
// ----------------------------------------------------------------------------
package lrr_pkg;

    localparam int COORD_BITS  = 10;
    localparam int ERR_W       = COORD_BITS + 3;
    localparam int STRAIGHT_W  = COORD_BITS + 2;
    localparam int IN_DATA_W   = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Input action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Shape kinds, read on a start beat only.
    localparam logic SHAPE_LINE = 1'b0;
    localparam logic SHAPE_RECT = 1'b1;

    // Rectangle edges in drawing order.
    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } t_edge;

    typedef struct packed {
        logic   action;
        logic   shape_kind;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
    } t_item;

    typedef struct packed {
        t_coord xs;
        t_coord ys;
        t_coord xe;
        t_coord ye;
    } t_seg;

    // Walk state of one segment; err and diag are two's complement.
    typedef struct packed {
        logic                  x_major;
        t_coord                cur_x;
        t_coord                cur_y;
        t_coord                stop;
        t_coord                target;
        logic [ERR_W-1:0]      err;
        logic [STRAIGHT_W-1:0] straight;
        logic [ERR_W-1:0]      diag;
    } t_walk;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   valid;
        logic   done;
    } t_pixel;

endpackage

[hdl/line_rectangle_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// Line and rectangle rasterizer, top level
// A taken input beat is parked in the input register; its pixel beat is offered from the output register.
// Throughput: one input beat and one pixel beat per cycle while pixel beats are drained.
// Reset (i_rst_n low at a clock edge) empties both registers and drops any shape.
// ----------------------------------------------------------------------------
module line_rectangle_rasterizer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, lowest bit up: x_start, y_start, x_end, y_end.
    input  logic [lrr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser, lowest bit up: action, shape_kind.
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, lowest bit up: pixel_x, pixel_y, zero fill.
    output logic [lrr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: pixel_valid.
    output logic [0:0]                     m_axis_tuser,
    // tlast: shape_done, set on the last pixel of the whole shape.
    output logic                           m_axis_tlast
);

    localparam int C = lrr_pkg::COORD_BITS;

    // An accepted beat is parked in the input register. The core steps on it
    // whenever the output register is empty or being drained, and the pixel
    // lands in the output register, so the input side takes a beat every
    // cycle while pixels are drained. While a pixel waits downstream, one more
    // beat is parked and then the input stalls.
    logic            r_in_vld;
    lrr_pkg::t_item  r_in;
    logic            r_out_vld;
    lrr_pkg::t_pixel r_out;
    logic            core_fire;
    lrr_pkg::t_pixel core_pixel;

    assign core_fire     = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || core_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.action     <= s_axis_tuser[0];
            r_in.shape_kind <= s_axis_tuser[1];
            r_in.x_start    <= s_axis_tdata[C-1:0];
            r_in.y_start    <= s_axis_tdata[2*C-1:C];
            r_in.x_end      <= s_axis_tdata[3*C-1:2*C];
            r_in.y_end      <= s_axis_tdata[4*C-1:3*C];
        end
    end

    // The core owns all shape state and updates it only on a step.
    lrr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (core_fire),
        .i_item  (r_in),
        .o_pixel (core_pixel)
    );

    // Output register: loaded on every step, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (core_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (core_fire) begin
            r_out <= core_pixel;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = lrr_pkg::OUT_DATA_W'({r_out.y, r_out.x});
    assign m_axis_tuser[0] = r_out.valid;
    assign m_axis_tlast    = r_out.done;

endmodule

[hdl/lrr_seg_setup.sv]
// ----------------------------------------------------------------------------
// Segment setup
// Picks the major axis, orders the ends and forms the Bresenham terms.
// ----------------------------------------------------------------------------
module lrr_seg_setup (
    input  lrr_pkg::t_seg  i_seg,
    output lrr_pkg::t_walk o_walk
);

    lrr_pkg::t_coord            dx, dy, maj, mnr;
    logic                       x_major, swap;
    logic [lrr_pkg::ERR_W-1:0]  maj_e, mnr_e;

    always_comb begin
        dx      = (i_seg.xs > i_seg.xe) ? i_seg.xs - i_seg.xe : i_seg.xe - i_seg.xs;
        dy      = (i_seg.ys > i_seg.ye) ? i_seg.ys - i_seg.ye : i_seg.ye - i_seg.ys;
        x_major = (dx >= dy);
        swap    = x_major ? !(i_seg.xs < i_seg.xe) : !(i_seg.ys < i_seg.ye);
        maj     = x_major ? dx : dy;
        mnr     = x_major ? dy : dx;
        maj_e   = lrr_pkg::ERR_W'(maj);
        mnr_e   = lrr_pkg::ERR_W'(mnr);

        o_walk.x_major  = x_major;
        o_walk.cur_x    = swap ? i_seg.xe : i_seg.xs;
        o_walk.cur_y    = swap ? i_seg.ye : i_seg.ys;
        if (x_major) begin
            o_walk.stop   = swap ? i_seg.xs : i_seg.xe;
            o_walk.target = swap ? i_seg.ys : i_seg.ye;
        end else begin
            o_walk.stop   = swap ? i_seg.ys : i_seg.ye;
            o_walk.target = swap ? i_seg.xs : i_seg.xe;
        end
        o_walk.err      = (mnr_e << 1) - maj_e;
        o_walk.straight = lrr_pkg::STRAIGHT_W'(mnr) << 1;
        o_walk.diag     = (mnr_e - maj_e) << 1;
    end

endmodule

[hdl/lrr_core.sv]
// ----------------------------------------------------------------------------
// Rasterizer core
// Holds the shape state and turns one beat into one pixel per cycle in which it is fired.
// ----------------------------------------------------------------------------
module lrr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  lrr_pkg::t_item  i_item,
    output lrr_pkg::t_pixel o_pixel
);

    lrr_pkg::t_walk  r_walk, n_walk, setup_walk;
    logic            r_active, n_active;
    logic            r_rect, n_rect;
    lrr_pkg::t_edge  r_edge, n_edge, edge_next;
    lrr_pkg::t_coord r_ax, r_ay, r_bx, r_by;
    lrr_pkg::t_coord n_ax, n_ay, n_bx, n_by;
    lrr_pkg::t_seg   seg;
    logic            at_stop, is_start, done;

    lrr_seg_setup u_setup (
        .i_seg  (seg),
        .o_walk (setup_walk)
    );

    always_comb begin
        is_start  = (i_item.action == lrr_pkg::ACT_START);
        at_stop   = (r_walk.x_major ? r_walk.cur_x : r_walk.cur_y) == r_walk.stop;
        edge_next = lrr_pkg::t_edge'(2'(r_edge + 2'd1));

        if (is_start) begin
            if (i_item.shape_kind == lrr_pkg::SHAPE_RECT)
                seg = '{i_item.x_start, i_item.y_start, i_item.x_end, i_item.y_start};
            else
                seg = '{i_item.x_start, i_item.y_start, i_item.x_end, i_item.y_end};
        end else begin
            case (edge_next)
                lrr_pkg::EDGE_TOP:    seg = '{r_ax, r_ay, r_bx, r_ay};
                lrr_pkg::EDGE_RIGHT:  seg = '{r_bx, r_ay, r_bx, r_by};
                lrr_pkg::EDGE_BOTTOM: seg = '{r_bx, r_by, r_ax, r_by};
                default:              seg = '{r_ax, r_by, r_ax, r_ay};
            endcase
        end
    end

    always_comb begin
        n_walk   = r_walk;
        n_active = r_active;
        n_rect   = r_rect;
        n_edge   = r_edge;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_bx     = r_bx;
        n_by     = r_by;
        done     = 1'b0;
        o_pixel  = '0;

        if (i_fire) begin
            if (is_start) begin
                n_ax     = i_item.x_start;
                n_ay     = i_item.y_start;
                n_bx     = i_item.x_end;
                n_by     = i_item.y_end;
                n_rect   = (i_item.shape_kind == lrr_pkg::SHAPE_RECT);
                n_edge   = lrr_pkg::EDGE_TOP;
                n_active = 1'b1;
                n_walk   = setup_walk;
            end else if (r_active && at_stop) begin
                n_edge = edge_next;
                n_walk = setup_walk;
            end else if (r_active) begin
                if (r_walk.err[lrr_pkg::ERR_W-1]) begin
                    n_walk.err = r_walk.err + lrr_pkg::ERR_W'(r_walk.straight);
                end else begin
                    if (r_walk.x_major)
                        n_walk.cur_y = (r_walk.cur_y < r_walk.target)
                                     ? r_walk.cur_y + lrr_pkg::t_coord'(1)
                                     : r_walk.cur_y - lrr_pkg::t_coord'(1);
                    else
                        n_walk.cur_x = (r_walk.cur_x > r_walk.target)
                                     ? r_walk.cur_x - lrr_pkg::t_coord'(1)
                                     : r_walk.cur_x + lrr_pkg::t_coord'(1);
                    n_walk.err = r_walk.err + r_walk.diag;
                end
                if (r_walk.x_major)
                    n_walk.cur_x = r_walk.cur_x + lrr_pkg::t_coord'(1);
                else
                    n_walk.cur_y = r_walk.cur_y + lrr_pkg::t_coord'(1);
            end

            if (is_start || r_active) begin
                done = ((n_walk.x_major ? n_walk.cur_x : n_walk.cur_y) == n_walk.stop)
                    && (!n_rect || n_edge == lrr_pkg::EDGE_LEFT);
                n_active = !done;
                o_pixel  = '{n_walk.cur_x, n_walk.cur_y, 1'b1, done};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_walk <= n_walk;
        r_rect <= n_rect;
        r_edge <= n_edge;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_bx   <= n_bx;
        r_by   <= n_by;
    end

endmodule

[hdl/lrr_checker.sv]
// ----------------------------------------------------------------------------
// Rasterizer port checker
// Watches the top level's ports for output behavior that must always hold.
// ----------------------------------------------------------------------------
`include "line_rectangle_rasterizer_unit_macros.svh"

module lrr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lrr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // A pixel beat that is held back keeps its contents.
    `LRR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "pixel beat changed while stalled")
    // The shape can only end on a drawn pixel.
    `LRR_ASSERT_IMPLY(a_last_valid, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0], "shape end on an empty beat")
    // An empty beat carries zero coordinates.
    `LRR_ASSERT_IMPLY(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0 && !m_axis_tlast, "empty beat with data")
    // A taken input beat is followed by a pixel beat on offer.
    `LRR_ASSERT_NEXT(a_in_to_out, $past(in_beat), m_axis_tvalid, "no pixel beat after an input beat")
    // Nothing is offered right after reset.
    `LRR_ASSERT_NEXT_NORST(a_reset_empty, !i_rst_n, !m_axis_tvalid, "pixel beat after reset")

endmodule

bind line_rectangle_rasterizer_unit lrr_checker u_lrr_checker (.*);
